### hw/rtl/cfa_rule_table_interpreter_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the CFA rule table interpreter checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef CFA_RULE_TABLE_INTERPRETER_CORE_MACROS_SVH
`define CFA_RULE_TABLE_INTERPRETER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CFA_RT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa_rt assertion failed");

// next-cycle implication, disabled while in reset
`define CFA_RT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa_rt assertion failed");

`endif

### hw/rtl/cfa_rt_pkg.sv
// ----------------------------------------------------------------------------
// cfa_rt_pkg
// Types and constants of the CFA rule table interpreter.
// ----------------------------------------------------------------------------
package cfa_rt_pkg;

  localparam int REG_W = 5;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_LOCATION = 1'b1;

  // call frame opcodes
  localparam logic [7:0] OP_NOP          = 8'h00;
  localparam logic [7:0] OP_SET_LOC      = 8'h01;
  localparam logic [7:0] OP_ADVANCE_LOC1 = 8'h02;
  localparam logic [7:0] OP_ADVANCE_LOC2 = 8'h03;
  localparam logic [7:0] OP_ADVANCE_LOC4 = 8'h04;
  localparam logic [7:0] OP_REGISTER     = 8'h09;
  localparam logic [7:0] OP_DEF_CFA      = 8'h0c;
  localparam logic [7:0] OP_DEF_CFA_REG  = 8'h0d;
  localparam logic [7:0] OP_DEF_CFA_OFS  = 8'h0e;
  // primary opcodes carried in the top two bits
  localparam logic [1:0] OP_HI_ADVANCE   = 2'b01;
  localparam logic [1:0] OP_HI_OFFSET    = 2'b10;

  // result status
  localparam logic [2:0] ST_APPLIED = 3'd0;
  localparam logic [2:0] ST_IGNORED = 3'd1;
  localparam logic [2:0] ST_STOPPED = 3'd2;
  localparam logic [2:0] ST_NOREG   = 3'd3;
  localparam logic [2:0] ST_BADOP   = 3'd4;

  // rule kinds
  localparam logic [1:0] KIND_UNDEF    = 2'd0;
  localparam logic [1:0] KIND_OFFSET   = 2'd1;
  localparam logic [1:0] KIND_REGISTER = 2'd2;
  localparam logic [1:0] KIND_CFA      = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [31:0] offset;
    logic [REG_W-1:0]  src;
  } rule_t;

  typedef struct packed {
    logic               begin_req;
    logic               clear_table;
    logic [7:0]         opcode;
    logic               reg_present;
    logic [REG_W-1:0]   first_reg;
    logic signed [31:0] first_arg;
    logic signed [31:0] second_arg;
    logic [REG_W-1:0]   second_reg;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [1:0]         rule_kind;
    logic signed [31:0] rule_offset;
    logic [REG_W-1:0]   rule_source_reg;
    logic               cfa_defined;
    logic [REG_W-1:0]   cfa_base_reg;
    logic signed [31:0] cfa_offset;
    logic signed [31:0] location;
  } out_item_t;

  // table update: optional clear of all rules, then optional write of one
  typedef struct packed {
    logic             en;
    logic             clr;
    logic [REG_W-1:0] idx;
    rule_t            rule;
  } tbl_wr_t;

endpackage

### hw/rtl/cfa_rt_rule_mem.sv
// ----------------------------------------------------------------------------
// cfa_rt_rule_mem
// Per-register rule store: one write port, one registered read port, and a
// valid bit per entry so that reset or a clear makes every rule undefined.
// ----------------------------------------------------------------------------
module cfa_rt_rule_mem #(
  parameter int NUM_REGS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [cfa_rt_pkg::REG_W-1:0]  rd_reg,
  output cfa_rt_pkg::rule_t             rd_rule,
  input  cfa_rt_pkg::tbl_wr_t           wr
);

  localparam int AW = $clog2(NUM_REGS);

  cfa_rt_pkg::rule_t  mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  logic [NUM_REGS-1:0] vld_nxt;
  cfa_rt_pkg::rule_t  rd_q_r;
  logic               rd_vld_r;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_hit;

  assign rd_addr = AW'(rd_reg);
  assign wr_addr = AW'(wr.idx);
  assign rd_hit  = 32'(rd_reg) < NUM_REGS;

  // a clear drops every entry, a write in the same cycle then sets its own
  always_comb begin
    vld_nxt = wr.clr ? '0 : vld_r;
    if (wr.en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.rule;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= rd_hit && vld_r[rd_addr];
      end
      vld_r <= vld_nxt;
    end
  end

  assign rd_rule = rd_vld_r ? rd_q_r : '0;

endmodule

### hw/rtl/cfa_rule_table_interpreter_core.sv
// ----------------------------------------------------------------------------
// cfa_rule_table_interpreter_core
// Call-frame instruction interpreter over a register rule table.
// ----------------------------------------------------------------------------
// Input channel in_*: one call-frame instruction per transaction. Output
// channel out_*: one result per instruction with the status, the rule of
// first_reg, the CFA rule and the location after the instruction.
// Both channels move a transaction when valid is high and stall is low.
// The cfg_* port writes stop_enable (index 0) and stop_location (index 1);
// it is always ready and must only be used while the block is idle.
// An instruction moves through the input register, then the result register.
// Throughput: one instruction per cycle while out_ is not stalled; the
// rule store read is issued at accept and a one-entry bypass covers the
// write of the instruction ahead.
// A stall on out_ holds the result register; the input register still
// takes one more instruction, after which in_stall follows out_stall.
// Synchronous reset clears the pipeline, location, halt flag, CFA rule,
// configuration, and marks every table rule undefined at once.
// ----------------------------------------------------------------------------
module cfa_rule_table_interpreter_core #(
  parameter int NUM_REGS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  cfa_rt_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output cfa_rt_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfa_rt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);

  // configuration
  logic        stop_en_r;
  logic [30:0] stop_loc_r;

  // pipeline
  logic                  s1_valid_r;
  cfa_rt_pkg::in_item_t  s1_r;
  logic                  s1_fwd_r;
  logic                  out_valid_r;
  cfa_rt_pkg::out_item_t out_r;

  // architectural state
  logic signed [31:0]             loc_r;
  logic                           halted_r;
  logic                           cfa_def_r;
  logic [cfa_rt_pkg::REG_W-1:0]   cfa_reg_r;
  logic signed [31:0]             cfa_ofs_r;
  cfa_rt_pkg::tbl_wr_t            lw_r;

  logic in_acc;
  logic s1_move;
  logic s1_adv;

  cfa_rt_pkg::rule_t   tbl_rd;
  cfa_rt_pkg::tbl_wr_t wr_nxt;
  cfa_rt_pkg::tbl_wr_t wr_commit;
  cfa_rt_pkg::rule_t   rule_cur;
  cfa_rt_pkg::rule_t   rule_nxt;
  cfa_rt_pkg::out_item_t res_nxt;

  logic signed [31:0]           loc_cur;
  logic signed [31:0]           loc_nxt;
  logic                         halt_cur;
  logic                         halt_nxt;
  logic                         cfa_def_nxt;
  logic [cfa_rt_pkg::REG_W-1:0] cfa_reg_nxt;
  logic signed [31:0]           cfa_ofs_nxt;
  logic [2:0]                   status;
  logic                         do_clr;
  logic                         in_rng;
  logic                         reg_ok;
  logic                         is_adv;
  logic                         is_ofs;
  logic                         loc_chg;
  logic                         past_stop;

  assign s1_move   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && s1_move;
  assign in_stall  = s1_valid_r && !s1_move;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  cfa_rt_rule_mem #(
    .NUM_REGS(NUM_REGS)
  ) u_rule_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_reg  (in_data.first_reg),
    .rd_rule (tbl_rd),
    .wr      (wr_commit)
  );

  always_comb begin
    do_clr = s1_r.begin_req && s1_r.clear_table;
    in_rng = 32'(s1_r.first_reg) < NUM_REGS;
    reg_ok = s1_r.reg_present && in_rng;
    is_adv = (s1_r.opcode[7:6] == cfa_rt_pkg::OP_HI_ADVANCE) ||
             (s1_r.opcode == cfa_rt_pkg::OP_ADVANCE_LOC1) ||
             (s1_r.opcode == cfa_rt_pkg::OP_ADVANCE_LOC2) ||
             (s1_r.opcode == cfa_rt_pkg::OP_ADVANCE_LOC4);
    is_ofs = s1_r.opcode[7:6] == cfa_rt_pkg::OP_HI_OFFSET;

    // rule as it stands before this instruction; the read was issued at
    // accept, so the instruction ahead may have updated it since
    if (s1_fwd_r && lw_r.en && (lw_r.idx == s1_r.first_reg)) begin
      rule_cur = lw_r.rule;
    end else if (s1_fwd_r && lw_r.clr) begin
      rule_cur = '0;
    end else begin
      rule_cur = tbl_rd;
    end
    if (do_clr) begin
      rule_cur = '0;
    end

    loc_cur     = s1_r.begin_req ? '0 : loc_r;
    halt_cur    = s1_r.begin_req ? 1'b0 : halted_r;
    cfa_def_nxt = do_clr ? 1'b0 : cfa_def_r;
    cfa_reg_nxt = do_clr ? '0 : cfa_reg_r;
    cfa_ofs_nxt = do_clr ? '0 : cfa_ofs_r;

    rule_nxt = rule_cur;
    loc_nxt  = loc_cur;
    halt_nxt = halt_cur;
    status   = cfa_rt_pkg::ST_APPLIED;
    loc_chg  = 1'b0;
    wr_nxt.en = 1'b0;

    if (halt_cur) begin
      status = cfa_rt_pkg::ST_IGNORED;
    end else if (!reg_ok) begin
      status   = cfa_rt_pkg::ST_NOREG;
      halt_nxt = 1'b1;
    end else if (is_adv) begin
      loc_nxt = loc_cur + s1_r.first_arg;
      loc_chg = 1'b1;
    end else if (is_ofs) begin
      rule_nxt.kind   = cfa_rt_pkg::KIND_OFFSET;
      rule_nxt.offset = s1_r.second_arg;
      wr_nxt.en       = 1'b1;
    end else begin
      case (s1_r.opcode)
        cfa_rt_pkg::OP_NOP: begin
        end
        cfa_rt_pkg::OP_SET_LOC: begin
          loc_nxt = s1_r.first_arg;
          loc_chg = 1'b1;
        end
        cfa_rt_pkg::OP_REGISTER: begin
          rule_nxt.kind = cfa_rt_pkg::KIND_REGISTER;
          rule_nxt.src  = s1_r.second_reg;
          wr_nxt.en     = 1'b1;
        end
        cfa_rt_pkg::OP_DEF_CFA: begin
          cfa_def_nxt = 1'b1;
          cfa_reg_nxt = s1_r.first_reg;
          cfa_ofs_nxt = s1_r.second_arg;
        end
        cfa_rt_pkg::OP_DEF_CFA_REG: begin
          cfa_def_nxt = 1'b1;
          cfa_reg_nxt = s1_r.first_reg;
        end
        cfa_rt_pkg::OP_DEF_CFA_OFS: begin
          cfa_def_nxt = 1'b1;
          cfa_ofs_nxt = s1_r.first_arg;
        end
        default: begin
          status   = cfa_rt_pkg::ST_BADOP;
          halt_nxt = 1'b1;
        end
      endcase
    end

    // signed location above a nonnegative bound
    past_stop = stop_en_r && !loc_nxt[31] && (loc_nxt[30:0] > stop_loc_r);
    if (loc_chg && past_stop) begin
      status   = cfa_rt_pkg::ST_STOPPED;
      halt_nxt = 1'b1;
    end

    wr_nxt.clr  = do_clr;
    wr_nxt.idx  = s1_r.first_reg;
    wr_nxt.rule = rule_nxt;

    wr_commit     = wr_nxt;
    wr_commit.en  = wr_nxt.en && s1_adv;
    wr_commit.clr = wr_nxt.clr && s1_adv;

    res_nxt.status          = status;
    res_nxt.rule_kind       = in_rng ? rule_nxt.kind : cfa_rt_pkg::KIND_UNDEF;
    res_nxt.rule_offset     = in_rng ? rule_nxt.offset : '0;
    res_nxt.rule_source_reg = in_rng ? rule_nxt.src : '0;
    res_nxt.cfa_defined     = cfa_def_nxt;
    res_nxt.cfa_base_reg    = cfa_reg_nxt;
    res_nxt.cfa_offset      = cfa_ofs_nxt;
    res_nxt.location        = loc_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_data;
    end
    if (s1_adv) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_en_r   <= 1'b0;
      stop_loc_r  <= '0;
      s1_valid_r  <= 1'b0;
      s1_fwd_r    <= 1'b0;
      out_valid_r <= 1'b0;
      loc_r       <= '0;
      halted_r    <= 1'b0;
      cfa_def_r   <= 1'b0;
      cfa_reg_r   <= '0;
      cfa_ofs_r   <= '0;
      lw_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfa_rt_pkg::CFG_STOP_ENABLE:   stop_en_r  <= cfg_data[0];
          cfa_rt_pkg::CFG_STOP_LOCATION: stop_loc_r <= cfg_data[30:0];
          default: begin
          end
        endcase
      end

      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_fwd_r   <= s1_adv;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        loc_r     <= loc_nxt;
        halted_r  <= halt_nxt;
        cfa_def_r <= cfa_def_nxt;
        cfa_reg_r <= cfa_reg_nxt;
        cfa_ofs_r <= cfa_ofs_nxt;
        lw_r      <= wr_commit;
      end
    end
  end

endmodule

### hw/rtl/cfa_rt_checker.sv
// ----------------------------------------------------------------------------
// cfa_rt_checker
// Port-level checks of the CFA rule table interpreter, bound to the top.
// ----------------------------------------------------------------------------
`include "cfa_rule_table_interpreter_core_macros.svh"

module cfa_rt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input cfa_rt_pkg::out_item_t out_data
);

  // nothing is presented right after reset releases
  `CFA_RT_ASSERT_SAME(a_idle_after_reset, $rose(rst_n), !out_valid)

  // a stalled result stays put
  `CFA_RT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // the CFA rule lives apart from the table
  `CFA_RT_ASSERT_SAME(a_no_cfa_kind, out_valid,
                      out_data.rule_kind != cfa_rt_pkg::KIND_CFA)

  // undefined rules (reset, clear, register out of range) have zero fields
  `CFA_RT_ASSERT_SAME(a_undef_zero,
                      out_valid && (out_data.rule_kind == cfa_rt_pkg::KIND_UNDEF),
                      (out_data.rule_offset == 0) && (out_data.rule_source_reg == 0))

  `CFA_RT_ASSERT_SAME(a_cfa_undef_zero, out_valid && !out_data.cfa_defined,
                      (out_data.cfa_base_reg == 0) && (out_data.cfa_offset == 0))

endmodule

bind cfa_rule_table_interpreter_core cfa_rt_checker u_cfa_rt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/cfa_rule_table_interpreter_core_checker.sv
// ----------------------------------------------------------------------------
// cfa_rule_table_interpreter_core_checker
// Watches the instruction, result and configuration channels of the call
// frame interpreter. Keeps its own rule table, CFA rule, location and halt
// state, works out the unwind row for every accepted instruction, and
// compares each returned row field by field, in order.
// ----------------------------------------------------------------------------
module cfa_rule_table_interpreter_core_checker #(
  parameter int NUM_REGS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  cfa_rt_pkg::in_item_t              in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  cfa_rt_pkg::out_item_t             out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [cfa_rt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data,
  output int                                mismatch_count,
  output int                                rows_in_flight,
  output int                                live_ops
);
  timeunit 1ns;
  timeprecision 1ps;

  cfa_rt_pkg::rule_t            rule_tbl [NUM_REGS];
  logic [31:0]                  loc_ctr;
  logic                         halted;
  logic                         cfa_def;
  logic [cfa_rt_pkg::REG_W-1:0] cfa_reg;
  logic [31:0]                  cfa_ofs;
  logic                         stop_en;
  logic [30:0]                  stop_loc;

  cfa_rt_pkg::out_item_t unwind_rows_q [$];
  int        n_err  = 0;
  int        n_live = 0;

  function automatic void clear_rules();
    for (int i = 0; i < NUM_REGS; i++) begin
      rule_tbl[i] = '0;
    end
    cfa_def = 1'b0;
    cfa_reg = '0;
    cfa_ofs = '0;
  endfunction

  // location is compared as a signed value against a nonnegative bound
  function automatic logic passed_stop(input logic [31:0] l);
    return stop_en && !l[31] && (l[30:0] > stop_loc);
  endfunction

  function automatic cfa_rt_pkg::out_item_t interpret_cfa_op(input cfa_rt_pkg::in_item_t op);
    cfa_rt_pkg::out_item_t row;
    logic      reg_ok;
    row    = '0;
    reg_ok = op.reg_present && (op.first_reg < NUM_REGS);
    if (op.begin_req) begin
      loc_ctr = '0;
      halted  = 1'b0;
      if (op.clear_table) clear_rules();
    end
    row.status = cfa_rt_pkg::ST_APPLIED;
    if (halted) begin
      row.status = cfa_rt_pkg::ST_IGNORED;
    end else if (!reg_ok) begin
      row.status = cfa_rt_pkg::ST_NOREG;
      halted     = 1'b1;
    end else if (op.opcode[7:6] == cfa_rt_pkg::OP_HI_ADVANCE ||
                 op.opcode == cfa_rt_pkg::OP_SET_LOC ||
                 op.opcode inside {cfa_rt_pkg::OP_ADVANCE_LOC1, cfa_rt_pkg::OP_ADVANCE_LOC2,
                                   cfa_rt_pkg::OP_ADVANCE_LOC4}) begin
      if (op.opcode == cfa_rt_pkg::OP_SET_LOC) loc_ctr = op.first_arg;
      else loc_ctr = loc_ctr + op.first_arg;
      if (passed_stop(loc_ctr)) begin
        row.status = cfa_rt_pkg::ST_STOPPED;
        halted     = 1'b1;
      end
    end else if (op.opcode[7:6] == cfa_rt_pkg::OP_HI_OFFSET) begin
      rule_tbl[op.first_reg].kind   = cfa_rt_pkg::KIND_OFFSET;
      rule_tbl[op.first_reg].offset = op.second_arg;
    end else begin
      case (op.opcode)
        cfa_rt_pkg::OP_NOP: begin
        end
        cfa_rt_pkg::OP_REGISTER: begin
          rule_tbl[op.first_reg].kind = cfa_rt_pkg::KIND_REGISTER;
          rule_tbl[op.first_reg].src  = op.second_reg;
        end
        cfa_rt_pkg::OP_DEF_CFA: begin
          cfa_def = 1'b1;
          cfa_reg = op.first_reg;
          cfa_ofs = op.second_arg;
        end
        cfa_rt_pkg::OP_DEF_CFA_REG: begin
          cfa_def = 1'b1;
          cfa_reg = op.first_reg;
        end
        cfa_rt_pkg::OP_DEF_CFA_OFS: begin
          cfa_def = 1'b1;
          cfa_ofs = op.first_arg;
        end
        default: begin
          row.status = cfa_rt_pkg::ST_BADOP;
          halted     = 1'b1;
        end
      endcase
    end
    // rule fields read after the update, zero when the register has no entry
    if (op.first_reg < NUM_REGS) begin
      row.rule_kind       = rule_tbl[op.first_reg].kind;
      row.rule_offset     = rule_tbl[op.first_reg].offset;
      row.rule_source_reg = rule_tbl[op.first_reg].src;
    end
    row.cfa_defined  = cfa_def;
    row.cfa_base_reg = cfa_reg;
    row.cfa_offset   = cfa_ofs;
    row.location     = loc_ctr;
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    cfa_rt_pkg::out_item_t row;
    if (!rst_n) begin
      clear_rules();
      loc_ctr  = '0;
      halted   = 1'b0;
      stop_en  = 1'b0;
      stop_loc = '0;
      unwind_rows_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cfa_rt_pkg::CFG_STOP_ENABLE:   stop_en  = cfg_data[0];
          cfa_rt_pkg::CFG_STOP_LOCATION: stop_loc = cfg_data[30:0];
          default: begin
          end
        endcase
      end
      // compare before taking new instructions so a row never matches its own edge
      if (out_valid && !out_stall) begin
        if (unwind_rows_q.size() == 0) begin
          n_err++;
          $error("result transaction with no instruction outstanding");
        end else begin
          row = unwind_rows_q.pop_front();
          check_field("status",          32'(row.status),          32'(out_data.status));
          check_field("rule_kind",       32'(row.rule_kind),       32'(out_data.rule_kind));
          check_field("rule_offset",     row.rule_offset,          out_data.rule_offset);
          check_field("rule_source_reg", 32'(row.rule_source_reg),
                      32'(out_data.rule_source_reg));
          check_field("cfa_defined",     32'(row.cfa_defined),     32'(out_data.cfa_defined));
          check_field("cfa_base_reg",    32'(row.cfa_base_reg),    32'(out_data.cfa_base_reg));
          check_field("cfa_offset",      row.cfa_offset,           out_data.cfa_offset);
          check_field("location",        row.location,             out_data.location);
        end
      end
      if (in_valid && !in_stall) begin
        row = interpret_cfa_op(in_data);
        n_live++;
        unwind_rows_q.push_back(row);
      end
    end
    mismatch_count <= n_err;
    rows_in_flight <= unwind_rows_q.size();
    live_ops       <= n_live;
  end

endmodule

### tb/cfa_rule_table_interpreter_core_test.sv
// ----------------------------------------------------------------------------
// cfa_rule_table_interpreter_core_test
// Drives call frame instruction streams into the interpreter: a directed
// pass over every opcode, the stop, wrap, halt and error cases, then random
// begin-delimited sequences under several stop settings, with random source
// gaps and result stalls. The checker beside the block judges every row.
// ----------------------------------------------------------------------------
module cfa_rule_table_interpreter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_REGS       = 32;
  localparam int LIVE_TARGET    = 1700;
  localparam int NUM_PHASES     = 7;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  cfa_rt_pkg::in_item_t            in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  cfa_rt_pkg::out_item_t           out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cfa_rt_pkg::CFG_IDX_W-1:0] cfg_index = cfa_rt_pkg::CFG_STOP_ENABLE;
  logic [31:0]                     cfg_data  = '0;

  logic idle_on      = 1'b1;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  int   mismatch_count;
  int   rows_in_flight;
  int   live_ops;

  always #10 clk = ~clk;

  cfa_rule_table_interpreter_core #(.NUM_REGS(NUM_REGS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cfa_rule_table_interpreter_core_checker #(.NUM_REGS(NUM_REGS)) row_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .rows_in_flight (rows_in_flight),
    .live_ops       (live_ops)
  );

  // result-side stalls: random bursts between free stretches
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left = $urandom_range(0, 40);
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 10);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cfa_rt_pkg::in_item_t mk_op(input logic b, input logic c,
                                                 input logic [7:0] opc,
                                                 input logic p, input logic [4:0] r1,
                                                 input logic [31:0] a1, input logic [31:0] a2,
                                                 input logic [4:0] r2);
    cfa_rt_pkg::in_item_t op;
    op.begin_req   = b;
    op.clear_table = c;
    op.opcode      = opc;
    op.reg_present = p;
    op.first_reg   = r1;
    op.first_arg   = a1;
    op.second_arg  = a2;
    op.second_reg  = r2;
    return op;
  endfunction

  // mostly well-formed instructions with small location steps so stops occur
  function automatic cfa_rt_pkg::in_item_t rand_op(input logic start_seq);
    cfa_rt_pkg::in_item_t op;
    op.begin_req   = start_seq;
    op.clear_table = start_seq ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
    op.reg_present = 1'b1;
    op.first_reg   = 5'($urandom);
    op.second_reg  = 5'($urandom);
    op.first_arg   = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 300);
    op.second_arg  = $urandom;
    op.opcode      = 8'($urandom);
    case ($urandom_range(0, 19))
      0, 1, 2:  op.opcode[7:6] = cfa_rt_pkg::OP_HI_ADVANCE;
      3:        op.opcode = cfa_rt_pkg::OP_ADVANCE_LOC1;
      4:        op.opcode = cfa_rt_pkg::OP_ADVANCE_LOC2;
      5:        op.opcode = cfa_rt_pkg::OP_ADVANCE_LOC4;
      6: begin
        op.opcode    = cfa_rt_pkg::OP_SET_LOC;
        op.first_arg = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6000);
      end
      7, 8, 9:  op.opcode[7:6] = cfa_rt_pkg::OP_HI_OFFSET;
      10, 11:   op.opcode = cfa_rt_pkg::OP_REGISTER;
      12:       op.opcode = cfa_rt_pkg::OP_DEF_CFA;
      13:       op.opcode = cfa_rt_pkg::OP_DEF_CFA_REG;
      14:       op.opcode = cfa_rt_pkg::OP_DEF_CFA_OFS;
      15:       op.opcode = cfa_rt_pkg::OP_NOP;
      16:       op.reg_present = 1'b0;
      17: begin
        // opcode left fully random
      end
      18: begin
        op.begin_req = 1'b1;
        op.opcode    = cfa_rt_pkg::OP_NOP;
      end
      default:  op.opcode = 8'($urandom_range(8'hc0, 8'hff));
    endcase
    return op;
  endfunction

  task automatic send_op(input cfa_rt_pkg::in_item_t op);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_sequence();
    int len;
    len = $urandom_range(1, 24);
    for (int k = 0; k < len; k++) send_op(rand_op(k == 0));
  endtask

  task automatic write_reg(input logic [cfa_rt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused data bits carry noise
  task automatic set_stop(input logic en, input logic [30:0] loc);
    logic [31:0] noise;
    noise = $urandom;
    write_reg(cfa_rt_pkg::CFG_STOP_ENABLE, {noise[31:1], en});
    noise = $urandom;
    write_reg(cfa_rt_pkg::CFG_STOP_LOCATION, {noise[31], loc});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (rows_in_flight != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase_goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_stop(1'b1, 31'h100);
    send_op(mk_op(1'b1, 1'b1, cfa_rt_pkg::OP_DEF_CFA,
                  1'b1, 5'd31, 32'h0, 32'h7fff_ffff, 5'd0));
    send_op(mk_op(1'b0, 1'b0, 8'h80,
                  1'b1, 5'd0, 32'h0, 32'h8000_0000, 5'd0));
    send_op(mk_op(1'b0, 1'b0, 8'hbf,
                  1'b1, 5'd31, 32'hffff_ffff, 32'hffff_ffff, 5'd31));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_REGISTER,
                  1'b1, 5'd5, 32'h0, 32'h0, 5'd31));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_REGISTER,
                  1'b1, 5'd31, 32'h0, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_DEF_CFA_REG,
                  1'b1, 5'd7, 32'h0, 32'h1234_5678, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_DEF_CFA_OFS,
                  1'b1, 5'd0, 32'h8000_0000, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_NOP,
                  1'b1, 5'd0, 32'hffff_ffff, 32'hffff_ffff, 5'd31));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_SET_LOC,
                  1'b1, 5'd0, 32'h10, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_ADVANCE_LOC1,
                  1'b1, 5'd0, 32'h20, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_ADVANCE_LOC2,
                  1'b1, 5'd0, 32'hffff_fff8, 32'h0, 5'd0));
    // location goes negative: no stop
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_ADVANCE_LOC4,
                  1'b1, 5'd0, 32'h7fff_ffff, 32'h0, 5'd0));
    // wraps through 2^32 back to zero
    send_op(mk_op(1'b0, 1'b0, 8'h40,
                  1'b1, 5'd0, 32'h7fff_ffd9, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, 8'h7f,
                  1'b1, 5'd0, 32'h101, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, 8'h80,
                  1'b1, 5'd0, 32'h0, 32'h55, 5'd0));
    send_op(mk_op(1'b1, 1'b0, cfa_rt_pkg::OP_NOP,
                  1'b1, 5'd5, 32'h0, 32'h0, 5'd0));
    // clear without begin has no effect
    send_op(mk_op(1'b0, 1'b1, cfa_rt_pkg::OP_NOP,
                  1'b1, 5'd0, 32'h0, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, 8'h81,
                  1'b0, 5'd3, 32'h0, 32'h77, 5'd0));
    send_op(mk_op(1'b1, 1'b0, 8'hff,
                  1'b1, 5'd0, 32'h0, 32'h0, 5'd0));
    send_op(mk_op(1'b1, 1'b0, 8'hc0,
                  1'b1, 5'd0, 32'h0, 32'h0, 5'd0));
    send_op(mk_op(1'b1, 1'b0, 8'h05,
                  1'b1, 5'd0, 32'h0, 32'h0, 5'd0));
    send_op(mk_op(1'b1, 1'b1, cfa_rt_pkg::OP_SET_LOC,
                  1'b1, 5'd31, 32'h100, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_SET_LOC,
                  1'b1, 5'd0, 32'hffff_ffff, 32'h0, 5'd0));
    send_op(mk_op(1'b0, 1'b0, cfa_rt_pkg::OP_DEF_CFA,
                  1'b1, 5'd0, 32'h0, 32'h0, 5'd0));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       set_stop(1'b0, 31'h0);
        1:       set_stop(1'b1, 31'h0);
        2:       set_stop(1'b1, 31'h7fff_ffff);
        3:       set_stop(1'b1, 31'($urandom_range(0, 4000)));
        4:       set_stop(1'b0, 31'h7fff_ffff);
        5:       set_stop(1'b1, 31'($urandom_range(0, 32'h7fff_ffff)));
        default: set_stop(1'b1, 31'($urandom_range(0, 4000)));
      endcase
      if (ph == NUM_PHASES - 1) idle_on <= 1'b0;
      phase_goal = live_ops + LIVE_TARGET / NUM_PHASES;
      while (live_ops < phase_goal) send_sequence();
      drain();
    end

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
